// ===== hw/rtl/imm_pkg.sv =====
// Shared types and constants of the integer matrix multiply unit.
// Used by imm_mac, imm_ctrl, integer_matrix_multiply_unit and the testbench.
package imm_pkg;

    localparam int MAX_N_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int              SIZE_W     = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    localparam logic MODE_LEFT  = 1'b0;
    localparam logic MODE_RIGHT = 1'b1;

    typedef enum logic [1:0] {
        S_LOAD,
        S_ISSUE,
        S_WAIT
    } t_state;

    typedef enum logic [1:0] {
        PASS_LL,
        PASS_LH,
        PASS_HL
    } t_pass;

    typedef struct packed {
        logic  valid;
        t_pass pass;
        logic  first;
        logic  last;
    } t_term;

endpackage

// ===== hw/rtl/imm_store.sv =====
// Matrix element memory: one write port, one read port with registered data.
// No package dependency.
module imm_store #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_WIDTH-1:0]    i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_WIDTH-1:0]    o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/imm_mac.sv =====
// Shared multiply-accumulate unit: one piece product per cycle, wrapping sum.
// Depends on imm_pkg for the term tag and pass codes.
module imm_mac #(
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imm_pkg::t_term        i_term,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    input  logic                  i_take,
    output logic [DATA_WIDTH-1:0] o_acc,
    output logic                  o_done
);
    import imm_pkg::*;

    localparam int PIECES = (DATA_WIDTH + 31) / 32;
    localparam int H      = (DATA_WIDTH + PIECES - 1) / PIECES;

    t_term                 r_t1;
    t_term                 r_t2;
    logic [DATA_WIDTH-1:0] r_prod;
    logic [DATA_WIDTH-1:0] r_acc;
    logic                  r_done;

    logic [H-1:0]          a_lo;
    logic [H-1:0]          a_hi;
    logic [H-1:0]          b_lo;
    logic [H-1:0]          b_hi;
    logic [H-1:0]          op_a;
    logic [H-1:0]          op_b;
    logic [2*H-1:0]        prod;
    logic [DATA_WIDTH-1:0] prod_w;
    logic [DATA_WIDTH-1:0] n_prod;

    assign a_lo   = H'(i_a);
    assign a_hi   = H'(i_a >> H);
    assign b_lo   = H'(i_b);
    assign b_hi   = H'(i_b >> H);
    assign prod   = (2*H)'(op_a) * (2*H)'(op_b);
    assign prod_w = DATA_WIDTH'(prod);

    always_comb begin
        unique case (r_t1.pass)
            PASS_LL: begin
                op_a   = a_lo;
                op_b   = b_lo;
                n_prod = prod_w;
            end
            PASS_LH: begin
                op_a   = a_lo;
                op_b   = b_hi;
                n_prod = prod_w << H;
            end
            PASS_HL: begin
                op_a   = a_hi;
                op_b   = b_lo;
                n_prod = prod_w << H;
            end
            default: begin
                op_a   = a_lo;
                op_b   = b_lo;
                n_prod = prod_w;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1   <= '0;
            r_t2   <= '0;
            r_done <= 1'b0;
        end else begin
            r_t1 <= i_term;
            r_t2 <= r_t1;
            if (r_t2.valid && r_t2.last) begin
                r_done <= 1'b1;
            end else if (i_take) begin
                r_done <= 1'b0;
            end
        end
        r_prod <= n_prod;
        if (r_t2.valid) begin
            r_acc <= (r_t2.first ? '0 : r_acc) + r_prod;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// ===== hw/rtl/imm_ctrl.sv =====
// Sequencer: element counts, store addressing and the multiply-accumulate schedule.
// Depends on imm_pkg for states, pass codes and the term tag.
module imm_ctrl #(
    parameter int MAX_N      = imm_pkg::MAX_N_DEF,
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [imm_pkg::SIZE_W-1:0]          i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    output logic                                o_left_we,
    output logic                                o_right_we,
    output logic [$clog2(MAX_N*MAX_N)-1:0]      o_wr_addr,
    output logic [$clog2(MAX_N*MAX_N)-1:0]      o_rd_left_addr,
    output logic [$clog2(MAX_N*MAX_N)-1:0]      o_rd_right_addr,
    output imm_pkg::t_term                      o_term,
    input  logic                                i_mac_done,
    input  logic                                i_out_free,
    output logic                                o_move,
    output logic [$clog2(MAX_N)-1:0]            o_row,
    output logic [$clog2(MAX_N)-1:0]            o_column,
    output logic                                o_final
);
    import imm_pkg::*;

    localparam int IW     = $clog2(MAX_N);
    localparam int AW     = $clog2(MAX_N * MAX_N);
    localparam int NW     = $clog2(MAX_N + 1);
    localparam int CW     = $clog2(MAX_N * MAX_N + 1);
    localparam int PIECES = (DATA_WIDTH + 31) / 32;
    localparam int NPASS  = (PIECES == 1) ? 1 : 3;

    function automatic logic [NW-1:0] f_sat(input logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return NW'(1);
        end
        if (int'(s) > MAX_N) begin
            return NW'(MAX_N);
        end
        return NW'(s);
    endfunction

    t_state        r_state, n_state;
    logic [NW-1:0] r_n, n_n;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_lcnt, n_lcnt;
    logic [CW-1:0] r_rcnt, n_rcnt;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [IW-1:0] r_k, n_k;
    t_pass         r_pass, n_pass;
    logic [AW-1:0] r_a_base, n_a_base;
    logic [AW-1:0] r_a_addr, n_a_addr;
    logic [AW-1:0] r_b_addr, n_b_addr;

    logic [NW-1:0] sat_n;
    logic [IW-1:0] n_last;
    logic          last_pass;
    logic          accept;
    logic          lwe;
    logic          rwe;

    assign sat_n     = f_sat(i_cfg_wr_data);
    assign n_last    = IW'(r_n - NW'(1));
    assign last_pass = (NPASS == 1) ? (r_pass == PASS_LL) : (r_pass == PASS_HL);
    assign o_ready   = (r_state == S_LOAD);
    assign accept    = i_valid && o_ready;
    assign lwe       = accept && (i_mode == MODE_LEFT) && (r_lcnt < r_total);
    assign rwe       = accept && (i_mode == MODE_RIGHT) && (r_rcnt < r_total);

    assign o_left_we       = lwe;
    assign o_right_we      = rwe;
    assign o_wr_addr       = (i_mode == MODE_RIGHT) ? r_rcnt[AW-1:0] : r_lcnt[AW-1:0];
    assign o_rd_left_addr  = r_a_addr;
    assign o_rd_right_addr = r_b_addr;
    assign o_row           = r_i;
    assign o_column        = r_j;
    assign o_final         = (r_i == n_last) && (r_j == n_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= f_sat(SIZE_RESET);
            r_total <= CW'(f_sat(SIZE_RESET)) * CW'(f_sat(SIZE_RESET));
            r_lcnt  <= '0;
            r_rcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_total <= n_total;
            r_lcnt  <= n_lcnt;
            r_rcnt  <= n_rcnt;
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_pass   <= n_pass;
        r_a_base <= n_a_base;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
    end

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_total      = r_total;
        n_lcnt       = r_lcnt + CW'(lwe);
        n_rcnt       = r_rcnt + CW'(rwe);
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_pass       = r_pass;
        n_a_base     = r_a_base;
        n_a_addr     = r_a_addr;
        n_b_addr     = r_b_addr;
        o_term       = '0;
        o_term.pass  = r_pass;
        o_term.first = (r_k == '0) && (r_pass == PASS_LL);
        o_term.last  = (r_k == n_last) && last_pass;
        o_move       = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (i_cfg_wr_en) begin
                    n_n     = sat_n;
                    n_total = CW'(sat_n) * CW'(sat_n);
                    n_lcnt  = '0;
                    n_rcnt  = '0;
                end else if ((n_lcnt == r_total) && (n_rcnt == r_total) && accept) begin
                    n_lcnt   = '0;
                    n_rcnt   = '0;
                    n_i      = '0;
                    n_j      = '0;
                    n_k      = '0;
                    n_pass   = PASS_LL;
                    n_a_base = '0;
                    n_a_addr = '0;
                    n_b_addr = '0;
                    n_state  = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_term.valid = 1'b1;
                if (last_pass) begin
                    n_pass = PASS_LL;
                    if (r_k == n_last) begin
                        n_state = S_WAIT;
                    end else begin
                        n_k      = r_k + IW'(1);
                        n_a_addr = r_a_addr + AW'(1);
                        n_b_addr = r_b_addr + AW'(r_n);
                    end
                end else begin
                    unique case (r_pass)
                        PASS_LL: n_pass = PASS_LH;
                        PASS_LH: n_pass = PASS_HL;
                        default: n_pass = PASS_LL;
                    endcase
                end
            end
            S_WAIT: begin
                if (i_mac_done && i_out_free) begin
                    o_move = 1'b1;
                    n_k    = '0;
                    n_pass = PASS_LL;
                    if (o_final) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ISSUE;
                        if (r_j == n_last) begin
                            n_i      = r_i + IW'(1);
                            n_j      = '0;
                            n_a_base = r_a_base + AW'(r_n);
                            n_a_addr = r_a_base + AW'(r_n);
                            n_b_addr = '0;
                        end else begin
                            n_j      = r_j + IW'(1);
                            n_a_addr = r_a_base;
                            n_b_addr = AW'(r_j) + AW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ===== hw/rtl/integer_matrix_multiply_unit.sv =====
// Top level of the integer matrix multiply unit: C = A x B, n x n, wrapping sums.
// Depends on imm_pkg, imm_store, imm_mac and imm_ctrl.
//
//  channel   signals                                         direction
//  config    i_cfg_wr_en, i_cfg_wr_data                      in, write only
//  input     i_valid, o_ready, i_mode, i_value               in
//  output    o_valid, i_ready, o_product, o_row, o_column,   out
//            o_final_res
//
// Loading accepts one transfer per cycle. Once both matrices are in, each of the
// n*n results takes n*P multiplier passes, followed by the accumulate pipeline and
// the handoff, where P is 1 for data up to 32 bits and 3 above (partial products).
// A single shared multiplier does all passes. Input is not ready while results are computed.
// Reset sets the size to 8 and clears both counts; the stores are not cleared.
// A stalled output holds the sequencer before the next result is handed off.
module integer_matrix_multiply_unit #(
    parameter int MAX_N      = imm_pkg::MAX_N_DEF,
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [imm_pkg::SIZE_W-1:0]    i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic signed [DATA_WIDTH-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [DATA_WIDTH-1:0]  o_product,
    output logic [$clog2(MAX_N)-1:0]      o_row,
    output logic [$clog2(MAX_N)-1:0]      o_column,
    output logic                          o_final_res
);
    import imm_pkg::*;

    localparam int IW    = $clog2(MAX_N);
    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = $clog2(DEPTH);

    logic                  left_we;
    logic                  right_we;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_left_addr;
    logic [AW-1:0]         rd_right_addr;
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;
    t_term                 term;
    logic [DATA_WIDTH-1:0] acc;
    logic                  mac_done;
    logic                  out_free;
    logic                  move;
    logic [IW-1:0]         row;
    logic [IW-1:0]         column;
    logic                  final_res;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_product;
    logic [IW-1:0]         r_row;
    logic [IW-1:0]         r_column;
    logic                  r_final_res;

    assign out_free = !r_out_valid || i_ready;

    imm_ctrl #(
        .MAX_N      (MAX_N),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .o_left_we       (left_we),
        .o_right_we      (right_we),
        .o_wr_addr       (wr_addr),
        .o_rd_left_addr  (rd_left_addr),
        .o_rd_right_addr (rd_right_addr),
        .o_term          (term),
        .i_mac_done      (mac_done),
        .i_out_free      (out_free),
        .o_move          (move),
        .o_row           (row),
        .o_column        (column),
        .o_final         (final_res)
    );

    imm_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_left_store (
        .i_clk     (i_clk),
        .i_we      (left_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_addr (rd_left_addr),
        .o_rd_data (left_data)
    );

    imm_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_right_store (
        .i_clk     (i_clk),
        .i_we      (right_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_addr (rd_right_addr),
        .o_rd_data (right_data)
    );

    imm_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_term  (term),
        .i_a     (left_data),
        .i_b     (right_data),
        .i_take  (move),
        .o_acc   (acc),
        .o_done  (mac_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (move) begin
            r_product   <= acc;
            r_row       <= row;
            r_column    <= column;
            r_final_res <= final_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_product   = r_product;
    assign o_row       = r_row;
    assign o_column    = r_column;
    assign o_final_res = r_final_res;

endmodule

// ===== tb/integer_matrix_multiply_unit_test.sv =====
// Self-checking testbench for integer_matrix_multiply_unit: streams A and B elements of
// square signed matrices and checks every element of the wrapped product C in order.
// Depends on imm_pkg and the integer_matrix_multiply_unit RTL.
module integer_matrix_multiply_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM        = imm_pkg::MAX_N_DEF;
    localparam int WORD_W         = imm_pkg::DATA_WIDTH_DEF;
    localparam int RANDOM_ITEMS   = 180;
    localparam int RANDOM_RESULTS = 48;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int LIMIT_CYCLES   = 300000;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] value;
    } t_element;

    typedef struct packed {
        logic signed [WORD_W-1:0] product;
        logic [2:0]               row;
        logic [2:0]               column;
        logic                     final_res;
    } t_product_elem;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [imm_pkg::SIZE_W-1:0]  i_cfg_wr_data = '0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic                        i_mode = imm_pkg::MODE_LEFT;
    logic signed [WORD_W-1:0]    i_value = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic signed [WORD_W-1:0]    o_product;
    logic [2:0]                  o_row;
    logic [2:0]                  o_column;
    logic                        o_final_res;

    // matrix model state
    logic [imm_pkg::SIZE_W-1:0]  size_reg = imm_pkg::SIZE_RESET;
    logic [WORD_W-1:0]           left_elems [MAX_DIM*MAX_DIM];
    logic [WORD_W-1:0]           right_elems [MAX_DIM*MAX_DIM];
    int unsigned                 left_fill = 0;
    int unsigned                 right_fill = 0;

    t_element                    pending_items [$];
    t_product_elem               product_q [$];
    t_element                    drive_item;
    t_product_elem               want;

    logic                        steady_run = 1'b0;
    logic                        hold_rx = 1'b0;
    logic                        hold_armed = 1'b0;
    int unsigned                 cycle_count = 0;
    int unsigned                 mismatches = 0;
    int unsigned                 transfers_in = 0;
    int unsigned                 ignored_in = 0;
    int unsigned                 results_seen = 0;
    int unsigned                 size_writes = 0;
    int unsigned                 rand_items = 0;
    int unsigned                 rand_results = 0;

    integer_matrix_multiply_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_product     (o_product),
        .o_row         (o_row),
        .o_column      (o_column),
        .o_final_res   (o_final_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned active_dim(logic [imm_pkg::SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_DIM) return MAX_DIM;
        return s;
    endfunction

    function automatic void take_element(logic mode, logic [WORD_W-1:0] v);
        int unsigned   n;
        int unsigned   total;
        logic [WORD_W-1:0] acc;
        t_product_elem e;
        n = active_dim(size_reg);
        total = n * n;
        if (mode == imm_pkg::MODE_LEFT) begin
            if (left_fill >= total) begin
                ignored_in++;
                return;
            end
            left_elems[left_fill] = v;
            left_fill++;
        end else begin
            if (right_fill >= total) begin
                ignored_in++;
                return;
            end
            right_elems[right_fill] = v;
            right_fill++;
        end
        if (left_fill < total || right_fill < total) return;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = '0;
                for (int k = 0; k < n; k++)
                    acc += left_elems[i*n + k] * right_elems[k*n + j];
                e.product   = acc;
                e.row       = 3'(i);
                e.column    = 3'(j);
                e.final_res = (i == n - 1 && j == n - 1);
                product_q.push_back(e);
            end
        end
        left_fill = 0;
        right_fill = 0;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_items.size() != 0 && (steady_run || $urandom_range(99) >= 32)) begin
                drive_item = pending_items.pop_front();
                i_valid <= 1'b1;
                i_mode  <= drive_item.mode;
                i_value <= drive_item.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !hold_rx && (steady_run || $urandom_range(99) >= 32);
        end
    end

    // hold off the receiver once while the sender keeps offering the next pair
    initial begin
        wait (hold_armed);
        do @(posedge i_clk); while (!o_valid);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // scoreboard: check results first, then update the model with this edge's transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (product_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: product %0d row %0d column %0d final %0b",
                                 o_product, o_row, o_column, o_final_res);
                end else begin
                    want = product_q.pop_front();
                    if (o_product !== want.product || o_row !== want.row ||
                        o_column !== want.column || o_final_res !== want.final_res) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch: expected %0d (%0d,%0d) final %0b, got %0d (%0d,%0d) final %0b",
                                     want.product, want.row, want.column, want.final_res,
                                     o_product, o_row, o_column, o_final_res);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                size_reg   = i_cfg_wr_data;
                left_fill  = 0;
                right_fill = 0;
            end
            if (i_valid && o_ready) begin
                transfers_in++;
                take_element(i_mode, i_value);
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_item(logic mode, logic [WORD_W-1:0] v);
        t_element it;
        it.mode  = mode;
        it.value = v;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_valid || product_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic reconfigure(logic [imm_pkg::SIZE_W-1:0] s);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= s;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        size_writes++;
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return '0;
            4, 5: return WORD_W'($signed($urandom_range(15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // full pair with random interleave; extras for an already full matrix are dropped
    task automatic queue_pair(logic [imm_pkg::SIZE_W-1:0] s);
        int unsigned t;
        int unsigned a;
        int unsigned b;
        t = active_dim(s) ** 2;
        a = 0;
        b = 0;
        while (a < t || b < t) begin
            if ((a == t || b == t) && $urandom_range(11) == 0) begin
                push_item(a == t ? imm_pkg::MODE_LEFT : imm_pkg::MODE_RIGHT, pick_value());
            end else if (b == t || (a < t && $urandom_range(1) == 0)) begin
                push_item(imm_pkg::MODE_LEFT, pick_value());
                a++;
                rand_items++;
            end else begin
                push_item(imm_pkg::MODE_RIGHT, pick_value());
                b++;
                rand_items++;
            end
        end
        rand_results += t;
    endtask

    // partial load that never completes; the next size write discards it
    task automatic queue_partial(logic [imm_pkg::SIZE_W-1:0] s);
        int unsigned t;
        int unsigned m;
        int unsigned a;
        int unsigned b;
        t = active_dim(s) ** 2;
        m = $urandom_range(1, (2*t - 1 < 24) ? 2*t - 1 : 24);
        a = 0;
        b = 0;
        repeat (m) begin
            if (b == t || (a < t && $urandom_range(1) == 0)) begin
                push_item(imm_pkg::MODE_LEFT, pick_value());
                a++;
            end else begin
                push_item(imm_pkg::MODE_RIGHT, pick_value());
                b++;
            end
            rand_items++;
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned pairs;
        logic [imm_pkg::SIZE_W-1:0] sz;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single element, extremes, extra element into a full matrix
        reconfigure(4'd1);
        push_item(imm_pkg::MODE_LEFT,  32'h7fff_ffff);
        push_item(imm_pkg::MODE_LEFT,  32'd5);
        push_item(imm_pkg::MODE_RIGHT, 32'h7fff_ffff);
        push_item(imm_pkg::MODE_LEFT,  32'h8000_0000);
        push_item(imm_pkg::MODE_RIGHT, 32'h8000_0000);
        push_item(imm_pkg::MODE_RIGHT, 32'hffff_ffff);
        push_item(imm_pkg::MODE_LEFT,  32'h8000_0000);

        // zero size behaves as one
        reconfigure(4'd0);
        push_item(imm_pkg::MODE_LEFT,  32'hffff_ffff);
        push_item(imm_pkg::MODE_RIGHT, 32'hffff_ffff);

        // size write in the middle of a load drops the partial pair
        reconfigure(4'd2);
        push_item(imm_pkg::MODE_LEFT,  32'd1);
        push_item(imm_pkg::MODE_RIGHT, 32'd2);
        push_item(imm_pkg::MODE_LEFT,  32'd3);
        reconfigure(4'd2);
        push_item(imm_pkg::MODE_RIGHT, 32'h7fff_ffff);
        push_item(imm_pkg::MODE_LEFT,  32'h7fff_ffff);
        push_item(imm_pkg::MODE_LEFT,  32'h8000_0000);
        push_item(imm_pkg::MODE_RIGHT, 32'hffff_ffff);
        push_item(imm_pkg::MODE_LEFT,  32'hffff_ffff);
        push_item(imm_pkg::MODE_RIGHT, 32'h8000_0000);
        push_item(imm_pkg::MODE_RIGHT, 32'd1);
        push_item(imm_pkg::MODE_LEFT,  32'd0);

        phase = 0;
        while (rand_items < RANDOM_ITEMS || rand_results < RANDOM_RESULTS || phase < 4) begin
            sz = 4'($urandom_range(0, 5));
            pairs = $urandom_range(1, 2);
            if (phase == 0) begin
                sz = 4'($urandom_range(2, 3));
                pairs = 2;
            end else if (phase == 1) begin
                sz = 4'd15;
                pairs = 1;
            end else if (phase == 3) begin
                sz = 4'd8;
                pairs = 0;
            end
            reconfigure(sz);
            steady_run <= (phase == 2);
            if (phase == 0) hold_armed = 1'b1;
            repeat (pairs) queue_pair(sz);
            if (phase == 3 || $urandom_range(2) == 0) queue_partial(sz);
            phase++;
        end

        wait_drained();
        steady_run <= 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run: %0d input transfers (%0d dropped as extras), %0d results checked,",
                 transfers_in, ignored_in, results_seen);
        $display("     %0d size writes over %0d random phases, %0d mismatches.",
                 size_writes, phase, mismatches);
        if (mismatches == 0 && product_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/imm_pkg.sv
hw/rtl/imm_store.sv
hw/rtl/imm_mac.sv
hw/rtl/imm_ctrl.sv
hw/rtl/integer_matrix_multiply_unit.sv
tb/integer_matrix_multiply_unit_test.sv
